/* hdl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/sleepq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sleepq_pkg;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_FLUSH = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    EV_DONE    = 3'd0,
    EV_POPPED  = 3'd1,
    EV_WOKEN   = 3'd2,
    EV_FLUSHED = 3'd3,
    EV_EMPTY   = 3'd4,
    EV_FULL    = 3'd5
  } event_e;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_SHIFT = 2'd1,
    CELL_LOAD  = 2'd2,
    CELL_DEC   = 2'd3
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_EXEC  = 2'd1,
    ST_SWEEP = 2'd2,
    ST_FLUSH = 2'd3
  } state_e;

endpackage

`default_nettype wire

/* hdl/sleepq_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module sleepq_cell
  import sleepq_pkg::*;
#(
  parameter int ID_BITS   = 8,
  parameter int TIME_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cell_op_e             op_i,
  input  wire logic [ID_BITS-1:0]   nb_id_i,
  input  wire logic [TIME_BITS-1:0] nb_rem_i,
  input  wire logic                 nb_exp_i,
  input  wire logic [ID_BITS-1:0]   ld_id_i,
  input  wire logic [TIME_BITS-1:0] ld_rem_i,
  output logic [ID_BITS-1:0]        id_o,
  output logic [TIME_BITS-1:0]      rem_o,
  output logic                      exp_o
);

  logic [ID_BITS-1:0]   id_q, id_d;
  logic [TIME_BITS-1:0] rem_q, rem_d;
  logic                 exp_q, exp_d;

  always_comb begin
    id_d  = id_q;
    rem_d = rem_q;
    exp_d = exp_q;
    unique case (op_i)
      CELL_HOLD: begin
      end
      CELL_SHIFT: begin
        id_d  = nb_id_i;
        rem_d = nb_rem_i;
        exp_d = nb_exp_i;
      end
      CELL_LOAD: begin
        id_d  = ld_id_i;
        rem_d = ld_rem_i;
        exp_d = 1'b0;
      end
      CELL_DEC: begin
        // untimed entries (zero) stay at zero
        if (rem_q != '0) begin
          rem_d = rem_q - TIME_BITS'(1);
        end
        exp_d = (rem_q == TIME_BITS'(1));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= 1'b0;
    end else begin
      exp_q <= exp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    rem_q <= rem_d;
  end

  assign id_o  = id_q;
  assign rem_o = rem_q;
  assign exp_o = exp_q;

endmodule

`default_nettype wire

/* hdl/thread_fifo_with_sleep_timeouts_top.sv */
// Push and pop: captured in IDLE, executed in EXEC, result registered; in_stall_o is high until IDLE again.
// Tick: a countdown over all held cells; if an entry expires, one rotation step per held entry follows,
//   each woken entry leaving on its step; without an expiry a single DONE result is emitted.
// Flush: one result per held entry, one per cycle unless the output stalls. Output stalls hold the cell row.
// Reset (rst_ni, async low): queue empty, no result pending; entry payload is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module thread_fifo_with_sleep_timeouts_top
  import sleepq_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int ID_BITS   = 8,
  parameter int TIME_BITS = 16,
  localparam int CW       = $clog2(DEPTH + 1)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [1:0]           cmd_i,
  input  wire logic [ID_BITS-1:0]   thread_id_i,
  input  wire logic [TIME_BITS-1:0] wait_ticks_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [ID_BITS-1:0]        thread_id_res_o,
  output logic [2:0]                event_res_o,
  output logic                      last_o,
  output logic [CW-1:0]             count_o
);

  state_e               state_q, state_d;
  cmd_e                 cmd_q;
  logic [ID_BITS-1:0]   tid_q;
  logic [TIME_BITS-1:0] wait_q;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        steps_q, steps_d;

  logic                 out_valid_q;
  logic [ID_BITS-1:0]   out_id_q;
  event_e               out_ev_q;
  logic                 out_last_q;
  logic [CW-1:0]        out_count_q;

  logic                 out_free;
  logic                 emit;
  event_e               ev;
  logic [ID_BITS-1:0]   res_id;
  logic                 last;
  logic                 do_push, do_shift, do_dec, keep_wrap;
  logic                 any_expire;

  cell_op_e             cell_op [DEPTH];
  logic [ID_BITS-1:0]   id_w    [DEPTH];
  logic [TIME_BITS-1:0] rem_w   [DEPTH];
  logic [DEPTH-1:0]     exp_w;
  logic [ID_BITS-1:0]   ld_id;
  logic [TIME_BITS-1:0] ld_rem;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    any_expire = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      if ((CW'(i) < count_q) && (rem_w[i] == TIME_BITS'(1))) begin
        any_expire = 1'b1;
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    steps_d   = steps_q;
    emit      = 1'b0;
    ev        = EV_DONE;
    res_id    = '0;
    last      = 1'b1;
    do_push   = 1'b0;
    do_shift  = 1'b0;
    do_dec    = 1'b0;
    keep_wrap = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          case (cmd_q)
            CMD_PUSH: begin
              emit    = 1'b1;
              state_d = ST_IDLE;
              if (count_q == CW'(DEPTH)) begin
                ev = EV_FULL;
              end else begin
                do_push = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            CMD_POP: begin
              emit    = 1'b1;
              state_d = ST_IDLE;
              if (count_q == '0) begin
                ev = EV_EMPTY;
              end else begin
                ev       = EV_POPPED;
                res_id   = id_w[0];
                do_shift = 1'b1;
                count_d  = count_q - CW'(1);
              end
            end
            CMD_TICK: begin
              do_dec = 1'b1;
              if (any_expire) begin
                steps_d = count_q;
                state_d = ST_SWEEP;
              end else begin
                emit    = 1'b1;
                state_d = ST_IDLE;
              end
            end
            CMD_FLUSH: begin
              if (count_q == '0) begin
                emit    = 1'b1;
                state_d = ST_IDLE;
              end else begin
                state_d = ST_FLUSH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SWEEP: begin
        if (out_free) begin
          do_shift = 1'b1;
          steps_d  = steps_q - CW'(1);
          if (exp_w[0]) begin
            emit    = 1'b1;
            ev      = EV_WOKEN;
            res_id  = id_w[0];
            last    = !(|exp_w[DEPTH-1:1]);
            count_d = count_q - CW'(1);
          end else begin
            keep_wrap = 1'b1;
          end
          if (steps_q == CW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          do_shift = 1'b1;
          emit     = 1'b1;
          ev       = EV_FLUSHED;
          res_id   = id_w[0];
          last     = (count_q == CW'(1));
          count_d  = count_q - CW'(1);
          if (count_q == CW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // kept entries rotate from the head to the vacated tail slot
  assign ld_id  = keep_wrap ? id_w[0]  : tid_q;
  assign ld_rem = keep_wrap ? rem_w[0] : wait_q;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_op[i] = CELL_HOLD;
      if (do_dec && (CW'(i) < count_q)) begin
        cell_op[i] = CELL_DEC;
      end else if (do_push && (CW'(i) == count_q)) begin
        cell_op[i] = CELL_LOAD;
      end else if (do_shift) begin
        if (keep_wrap && (CW'(i) == count_q - CW'(1))) begin
          cell_op[i] = CELL_LOAD;
        end else begin
          cell_op[i] = CELL_SHIFT;
        end
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [ID_BITS-1:0]   nb_id;
    logic [TIME_BITS-1:0] nb_rem;
    logic                 nb_exp;
    if (g == DEPTH - 1) begin : g_end
      assign nb_id  = '0;
      assign nb_rem = '0;
      assign nb_exp = 1'b0;
    end else begin : g_mid
      assign nb_id  = id_w[g+1];
      assign nb_rem = rem_w[g+1];
      assign nb_exp = exp_w[g+1];
    end
    sleepq_cell #(
      .ID_BITS  (ID_BITS),
      .TIME_BITS(TIME_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (cell_op[g]),
      .nb_id_i (nb_id),
      .nb_rem_i(nb_rem),
      .nb_exp_i(nb_exp),
      .ld_id_i (ld_id),
      .ld_rem_i(ld_rem),
      .id_o    (id_w[g]),
      .rem_o   (rem_w[g]),
      .exp_o   (exp_w[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      steps_q <= steps_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      cmd_q  <= cmd_e'(cmd_i);
      tid_q  <= thread_id_i;
      wait_q <= wait_ticks_i;
    end
    if (emit) begin
      out_id_q    <= res_id;
      out_ev_q    <= ev;
      out_last_q  <= last;
      out_count_q <= count_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign thread_id_res_o = out_id_q;
  assign event_res_o     = out_ev_q;
  assign last_o          = out_last_q;
  assign count_o         = out_count_q;

endmodule

`default_nettype wire

/* hdl/sleepq_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sleepq_checker
  import sleepq_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int ID_BITS   = 8,
  parameter int TIME_BITS = 16,
  localparam int CW       = $clog2(DEPTH + 1)
) (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_stall_o,
  input wire logic [1:0]           cmd_i,
  input wire logic [ID_BITS-1:0]   thread_id_i,
  input wire logic [TIME_BITS-1:0] wait_ticks_i,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire logic [ID_BITS-1:0]   thread_id_res_o,
  input wire logic [2:0]           event_res_o,
  input wire logic                 last_o,
  input wire logic [CW-1:0]        count_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  `SQ_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                 out_valid_o && $stable(event_res_o) && $stable(count_o))
  `SQ_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_acc, in_stall_o)
  `SQ_ASSERT_IMP(a_full_count, clk_i, rst_ni, out_valid_o && event_res_o == EV_FULL,
                 count_o == CW'(DEPTH) && last_o)
  `SQ_ASSERT_IMP(a_empty_count, clk_i, rst_ni, out_valid_o && event_res_o == EV_EMPTY,
                 count_o == '0 && last_o)
  `SQ_ASSERT_IMP(a_flush_end, clk_i, rst_ni,
                 out_valid_o && event_res_o == EV_FLUSHED,
                 last_o == (count_o == '0))

endmodule

bind thread_fifo_with_sleep_timeouts_top sleepq_checker #(
  .DEPTH    (DEPTH),
  .ID_BITS  (ID_BITS),
  .TIME_BITS(TIME_BITS)
) u_sleepq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .cmd_i          (cmd_i),
  .thread_id_i    (thread_id_i),
  .wait_ticks_i   (wait_ticks_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .thread_id_res_o(thread_id_res_o),
  .event_res_o    (event_res_o),
  .last_o         (last_o),
  .count_o        (count_o)
);

`default_nettype wire
